>>> src/lrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrm_pkg;

    localparam int POS_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int GAIN_W     = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam int unsigned DEFAULT_STEP_COUNTS = 100;

    // Q16.16 constants
    localparam logic [GAIN_W-1:0]       GAIN_RESET  = 24'd65536;
    localparam logic [POS_W-1:0]        MAX_MOVE_Q  = 32'd19660800;   // 300.0
    localparam logic signed [POS_W-1:0] POS_LIMIT_Q = 32'sd11141120;  // +170.0
    localparam logic signed [POS_W-1:0] NEG_LIMIT_Q = -32'sd11141120; // -170.0
    localparam logic signed [POS_W-1:0] HOME_Q      = -32'sd6553600;  // -100.0
    localparam logic signed [POS_W-1:0] POS_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN     = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ENABLED   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARCSEC_PER_COUNT = 1'b1;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_STEPPING  = 4'd1,
        ST_DISABLED  = 4'd2,
        ST_TOO_LARGE = 4'd3,
        ST_BLOCK_POS = 4'd4,
        ST_BLOCK_NEG = 4'd5,
        ST_STOP_POS  = 4'd6,
        ST_STOP_NEG  = 4'd7,
        ST_STOP_HOME = 4'd8,
        ST_DONE      = 4'd9
    } status_t;

    typedef struct packed {
        logic                      action;
        logic signed [COUNT_W-1:0] relative_counts;
        logic                      home_stop;
    } lrm_item_t;

    typedef struct packed {
        logic                      device_enabled;
        logic [GAIN_W-1:0]         arcsec_per_count;
    } lrm_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   position;
        logic                      moving;
        logic                      positive_limit;
        logic                      negative_limit;
        logic                      home_flag;
        logic signed [COUNT_W-1:0] counts_left;
        status_t                   status;
    } lrm_result_t;

endpackage

`default_nettype wire

>>> src/lrm_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lrm_cmd_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] relative_counts;
    logic               home_stop;

    modport source (output valid, output action, output relative_counts,
                    output home_stop, input ready);
    modport sink   (input valid, input action, input relative_counts,
                    input home_stop, output ready);
endinterface

`default_nettype wire

>>> src/lrm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lrm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic               moving;
    logic               positive_limit;
    logic               negative_limit;
    logic               home_flag;
    logic signed [31:0] counts_left;
    logic [3:0]         status;

    modport source (output valid, output position, output moving,
                    output positive_limit, output negative_limit,
                    output home_flag, output counts_left, output status,
                    input ready);
    modport sink   (input valid, input position, input moving,
                    input positive_limit, input negative_limit,
                    input home_flag, input counts_left, input status,
                    output ready);
endinterface

`default_nettype wire

>>> src/lrm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module lrm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            write_en,
    input  logic [lrm_pkg::CFG_IDX_W-1:0]   index,
    input  logic [lrm_pkg::CFG_DATA_W-1:0]  data,
    output lrm_pkg::lrm_cfg_t               cfg
);
    import lrm_pkg::*;

    lrm_cfg_t cfg_reg;
    lrm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (index)
                CFG_DEVICE_ENABLED:   cfg_next.device_enabled   = data[0];
                CFG_ARCSEC_PER_COUNT: cfg_next.arcsec_per_count = data[GAIN_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_enabled   <= 1'b0;
            cfg_reg.arcsec_per_count <= GAIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/lrm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module lrm_core #(
    parameter int unsigned STEP_COUNTS = lrm_pkg::DEFAULT_STEP_COUNTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  lrm_pkg::lrm_item_t   item,
    input  lrm_pkg::lrm_cfg_t    cfg,
    output lrm_pkg::lrm_result_t result
);
    import lrm_pkg::*;

    // signed step size, wide enough for +/-STEP_COUNTS
    localparam int STEP_W = $clog2(STEP_COUNTS + 1);
    localparam int CNT_W  = STEP_W + 1;
    localparam int PROD_W = CNT_W + GAIN_W + 1;
    localparam int SUM_W  = ((PROD_W > POS_W) ? PROD_W : POS_W) + 1;
    localparam int MOVE_W = COUNT_W + GAIN_W;

    localparam logic [COUNT_W-1:0]      STEP_MAG = COUNT_W'(STEP_COUNTS);
    localparam logic signed [CNT_W-1:0] STEP_POS = CNT_W'(STEP_COUNTS);
    localparam logic signed [CNT_W-1:0] STEP_NEG = -STEP_POS;
    localparam logic signed [SUM_W-1:0] SAT_MAX  = SUM_W'(POS_MAX);
    localparam logic signed [SUM_W-1:0] SAT_MIN  = SUM_W'(POS_MIN);

    logic signed [POS_W-1:0]   position_reg, position_next;
    logic signed [COUNT_W-1:0] counts_left_reg, counts_left_next;
    logic                      moving_reg, moving_next;
    logic                      direction_reg, direction_next;
    logic                      positive_limit_reg, positive_limit_next;
    logic                      negative_limit_reg, negative_limit_next;
    logic                      home_flag_reg, home_flag_next;
    status_t                   status;

    logic [COUNT_W-1:0]        rel_mag;
    logic [MOVE_W-1:0]         move_q;
    logic                      too_large;
    logic                      rel_neg;
    logic [COUNT_W-1:0]        left_mag;
    logic                      last_step;
    logic signed [CNT_W-1:0]   step_counts;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W-1:0]   sum;
    logic signed [POS_W-1:0]   sat_pos;
    logic                      hit_pos, hit_neg, hit_home;

    // start: size check on |counts| * gain
    assign rel_neg   = item.relative_counts[COUNT_W-1];
    assign rel_mag   = rel_neg ? (~item.relative_counts + 1'b1) : item.relative_counts;
    assign move_q    = rel_mag * cfg.arcsec_per_count;
    assign too_large = move_q > MOVE_W'(MAX_MOVE_Q);

    // tick: one step, or the remainder on the last step
    assign left_mag    = counts_left_reg[COUNT_W-1] ? (~counts_left_reg + 1'b1)
                                                    : counts_left_reg;
    assign last_step   = left_mag <= STEP_MAG;
    assign step_counts = last_step ? counts_left_reg[CNT_W-1:0]
                                   : (direction_reg ? STEP_NEG : STEP_POS);
    assign prod        = step_counts * $signed({1'b0, cfg.arcsec_per_count});
    assign sum         = position_reg + prod;
    assign sat_pos     = (sum > SAT_MAX) ? POS_MAX :
                         (sum < SAT_MIN) ? POS_MIN : sum[POS_W-1:0];

    assign hit_pos  = sat_pos > POS_LIMIT_Q;
    assign hit_neg  = sat_pos < NEG_LIMIT_Q;
    assign hit_home = sat_pos >= HOME_Q;

    always_comb
    begin
        position_next       = position_reg;
        counts_left_next    = counts_left_reg;
        moving_next         = moving_reg;
        direction_next      = direction_reg;
        positive_limit_next = positive_limit_reg;
        negative_limit_next = negative_limit_reg;
        home_flag_next      = home_flag_reg;
        status              = ST_IDLE;

        if (item.action == ACTION_START)
        begin
            if (moving_reg)
                status = ST_STEPPING;
            else if (!cfg.device_enabled)
                status = ST_DISABLED;
            else if (too_large)
                status = ST_TOO_LARGE;
            else if (rel_neg && negative_limit_reg)
                status = ST_BLOCK_NEG;
            else if (!rel_neg && positive_limit_reg)
                status = ST_BLOCK_POS;
            else
            begin
                direction_next   = rel_neg;
                counts_left_next = item.relative_counts;
                moving_next      = 1'b1;
                status           = ST_STEPPING;
            end
        end
        else if (moving_reg)
        begin
            position_next = sat_pos;
            if (last_step)
            begin
                // remainder leaves the flags as they are
                counts_left_next = '0;
                moving_next      = 1'b0;
                status           = ST_DONE;
            end
            else
            begin
                positive_limit_next = hit_pos;
                if (hit_pos && !direction_reg)
                begin
                    counts_left_next = '0;
                    moving_next      = 1'b0;
                    status           = ST_STOP_POS;
                end
                else
                begin
                    negative_limit_next = hit_neg;
                    if (hit_neg && direction_reg)
                    begin
                        counts_left_next = '0;
                        moving_next      = 1'b0;
                        status           = ST_STOP_NEG;
                    end
                    else
                    begin
                        home_flag_next = hit_home;
                        if (hit_home && item.home_stop)
                        begin
                            counts_left_next = '0;
                            moving_next      = 1'b0;
                            status           = ST_STOP_HOME;
                        end
                        else
                        begin
                            counts_left_next = direction_reg
                                ? counts_left_reg + COUNT_W'(STEP_COUNTS)
                                : counts_left_reg - COUNT_W'(STEP_COUNTS);
                            status = ST_STEPPING;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg       <= '0;
            counts_left_reg    <= '0;
            moving_reg         <= 1'b0;
            direction_reg      <= 1'b0;
            positive_limit_reg <= 1'b0;
            negative_limit_reg <= 1'b0;
            home_flag_reg      <= 1'b0;
        end
        else if (fire)
        begin
            position_reg       <= position_next;
            counts_left_reg    <= counts_left_next;
            moving_reg         <= moving_next;
            direction_reg      <= direction_next;
            positive_limit_reg <= positive_limit_next;
            negative_limit_reg <= negative_limit_next;
            home_flag_reg      <= home_flag_next;
        end
    end

    always_comb
    begin
        result.position       = position_next;
        result.moving         = moving_next;
        result.positive_limit = positive_limit_next;
        result.negative_limit = negative_limit_next;
        result.home_flag      = home_flag_next;
        result.counts_left    = counts_left_next;
        result.status         = status;
    end

endmodule

`default_nettype wire

>>> src/limited_relative_move_simulator.sv
`timescale 1ns / 1ps
`default_nettype none
// Stepped relative move simulator.
// cmd channel (valid/ready): action 0 starts a relative move of
// relative_counts, action 1 is one time tick (home_stop used on ticks).
// rsp channel (valid/ready): one item per cmd item, giving position
// (Q16.16 arcsec), moving, limit and home flags, counts_left and status.
// cfg_write_en/cfg_index/cfg_data write device_enabled (index 0) and
// arcsec_per_count (index 1); write only while no item is in flight.
// A cmd item is taken into the input stage, then processed into the result
// register that drives rsp. Throughput: one item per cycle while rsp is not
// stalled; the motion state update is a single multiply, saturating add and
// compare between the input stage and the result register, so each item
// sees the state left by the one before.
// When rsp is stalled, the result register holds and one more cmd item is
// taken into the input stage; after that cmd.ready drops until rsp drains.
// Reset clears the motion state and flags, disables the device and sets
// the gain to 1.0 arcsec per count; no item is held after reset.
module limited_relative_move_simulator #(
    parameter int unsigned STEP_COUNTS = lrm_pkg::DEFAULT_STEP_COUNTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [lrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lrm_pkg::CFG_DATA_W-1:0]  cfg_data,
    lrm_cmd_if.sink                         cmd,
    lrm_rsp_if.source                       rsp
);
    import lrm_pkg::*;

    lrm_cfg_t    cfg;
    lrm_item_t   item_reg;
    logic        item_vld_reg, item_vld_next;
    lrm_result_t result;
    lrm_result_t result_reg;
    logic        rsp_vld_reg, rsp_vld_next;
    logic        cmd_accept;
    logic        advance;

    lrm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .data     (cfg_data),
        .cfg      (cfg)
    );

    assign advance       = item_vld_reg && (!rsp_vld_reg || rsp.ready);
    assign cmd.ready     = !item_vld_reg || advance;
    assign cmd_accept    = cmd.valid && cmd.ready;
    assign item_vld_next = cmd_accept || (item_vld_reg && !advance);
    assign rsp_vld_next  = advance || (rsp_vld_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            rsp_vld_reg  <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            item_reg.action          <= cmd.action;
            item_reg.relative_counts <= cmd.relative_counts;
            item_reg.home_stop       <= cmd.home_stop;
        end
        if (advance)
            result_reg <= result;
    end

    lrm_core #(
        .STEP_COUNTS (STEP_COUNTS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.position       = result_reg.position;
    assign rsp.moving         = result_reg.moving;
    assign rsp.positive_limit = result_reg.positive_limit;
    assign rsp.negative_limit = result_reg.negative_limit;
    assign rsp.home_flag      = result_reg.home_flag;
    assign rsp.counts_left    = result_reg.counts_left;
    assign rsp.status         = result_reg.status;

    // an item that is processed always shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_vld_reg)
        else $error("processed item did not reach the result register");

    // a stalled input stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        item_vld_reg && !advance |=> item_vld_reg && $stable(item_reg))
        else $error("input stage item lost while stalled");

    // no move in progress means nothing left to move
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && !result_reg.moving |-> result_reg.counts_left == '0)
        else $error("counts left while not moving");

    // a move that ends is no longer moving
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && (result_reg.status == ST_DONE || result_reg.status == ST_STOP_POS ||
                        result_reg.status == ST_STOP_NEG || result_reg.status == ST_STOP_HOME)
        |-> !result_reg.moving)
        else $error("ended move still flagged as moving");

endmodule

`default_nettype wire
